>>> hdl/ric_pkg.sv
// Shared types and constants for the range instruction coalescer.
// Used by every module of the block; depends on nothing else.
package ric_pkg;

  // Width of the slot and count fields of an item
  localparam int RIC_FIELD_W = 8;
  // Width of an opaque instruction word
  localparam int RIC_WORD_W = 32;
  // Default number of significant slot bits
  localparam int RIC_SLOT_BITS_DEF = 8;
  // Largest count that a merged instruction may carry
  localparam logic [RIC_FIELD_W:0] RIC_MAX_COUNT = (RIC_FIELD_W + 1)'(255);

  // Stream widths
  localparam int RIC_S_TDATA_W = 64;
  localparam int RIC_M_TDATA_W = 56;

  // Request modes carried in the input tuser
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_COPY   = 2'd1,
    MODE_OPAQUE = 2'd2,
    MODE_FLUSH  = 2'd3
  } mode_t;

  // Kinds of emitted instruction
  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_SINGLE = 3'd1,
    KIND_MULTI  = 3'd2,
    KIND_VAR    = 3'd3,
    KIND_OPAQUE = 3'd4
  } kind_t;

  // One request item after unpacking
  typedef struct packed {
    mode_t                  mode;
    logic [RIC_FIELD_W-1:0] dest;
    logic [RIC_FIELD_W-1:0] source;
    logic [RIC_FIELD_W-1:0] count;
    logic                   var_count;
    logic                   jump_target;
    logic [RIC_WORD_W-1:0]  word;
  } req_t;

  // One emitted instruction
  typedef struct packed {
    kind_t                  kind;
    logic [RIC_FIELD_W-1:0] dest;
    logic [RIC_FIELD_W-1:0] source;
    logic [RIC_FIELD_W-1:0] count;
    logic [RIC_WORD_W-1:0]  word;
  } res_t;

endpackage

>>> hdl/range_instruction_coalescer.sv
// Range instruction coalescer: peephole merging of clear-range and copy-range
// items into one pending instruction. One item is accepted every cycle while the
// result register is free or being drained; an item passes the input register,
// the merge logic and the result register. Each item causes at most one result,
// always with tlast set. Depends on ric_pkg, ric_in_reg, ric_core and ric_out_reg.
module range_instruction_coalescer #(
  parameter int SLOT_BITS = ric_pkg::RIC_SLOT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: dest_slot[7:0], source_slot[15:8], slot_count[23:16],
  //          variable_count[24], at_jump_target[25], opaque_word[57:26], zeros
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ric_pkg::RIC_S_TDATA_W-1:0] s_tdata,
  // s_tuser: mode[1:0]
  input  logic [1:0]                        s_tuser,
  // m_tdata: out_dest[7:0], out_source[15:8], out_count[23:16], out_word[55:24]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ric_pkg::RIC_M_TDATA_W-1:0] m_tdata,
  // m_tuser: out_kind[2:0]
  output logic [2:0]                        m_tuser,
  output logic                              m_tlast
);
  import ric_pkg::*;

  req_t req_in;
  req_t req;
  logic req_valid;
  logic advance;
  logic emit;
  res_t result;
  res_t out_res;

  // Unpack the incoming item
  assign req_in.mode        = mode_t'(s_tuser);
  assign req_in.dest        = s_tdata[7:0];
  assign req_in.source      = s_tdata[15:8];
  assign req_in.count       = s_tdata[23:16];
  assign req_in.var_count   = s_tdata[24];
  assign req_in.jump_target = s_tdata[25];
  assign req_in.word        = s_tdata[57:26];

  // An item moves on when the result register is free or being drained
  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  ric_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (s_tvalid && s_tready),
    .advance   (advance),
    .req_in    (req_in),
    .req_valid (req_valid),
    .req       (req)
  );

  ric_core #(
    .SLOT_BITS (SLOT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .req    (req),
    .emit   (emit),
    .result (result)
  );

  ric_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .emit      (emit),
    .result    (result),
    .taken     (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  // Pack the result item
  assign m_tdata = {out_res.word, out_res.count, out_res.source, out_res.dest};
  assign m_tuser = out_res.kind;
  assign m_tlast = 1'b1;

endmodule

>>> hdl/ric_in_reg.sv
// Input register of the coalescer: captures one request item per cycle while load is set.
// Depends on ric_pkg for the request type.
module ric_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          advance,
  input  ric_pkg::req_t req_in,
  output logic          req_valid,
  output ric_pkg::req_t req
);
  import ric_pkg::*;

  // Valid flag: set by a new item, cleared once the item has been processed
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (load) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      req <= req_in;
    end
  end

endmodule

>>> hdl/ric_core.sv
// Merge decision and pending instruction register of the coalescer.
// Depends on ric_pkg for request, result and kind types.
module ric_core #(
  parameter int SLOT_BITS = ric_pkg::RIC_SLOT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  ric_pkg::req_t req,
  output logic          emit,
  output ric_pkg::res_t result
);
  import ric_pkg::*;

  localparam int SW = (SLOT_BITS < RIC_FIELD_W) ? SLOT_BITS : RIC_FIELD_W;
  localparam int EW = RIC_FIELD_W + 1;

  logic                   pend_valid;
  res_t                   pend;
  logic                   pend_valid_next;
  res_t                   pend_next;

  logic [RIC_FIELD_W-1:0] t;
  logic [RIC_FIELD_W-1:0] f;
  logic [EW-1:0]          t_w;
  logic [EW-1:0]          f_w;
  logic [EW-1:0]          n_w;
  logic [EW-1:0]          pt_w;
  logic [EW-1:0]          pf_w;
  logic [EW-1:0]          pn_w;
  logic [EW-1:0]          t_end;
  logic [EW-1:0]          f_end;
  logic [EW-1:0]          pt_end;
  logic [EW-1:0]          pf_end;
  logic [EW-1:0]          lo_dest;
  logic [EW-1:0]          hi_dest;
  logic [EW-1:0]          new_count;
  logic                   count_ok;
  logic                   clear_merge;
  logic                   copy_merge;
  logic                   merge;

  // Slots are taken modulo the slot width
  assign t = RIC_FIELD_W'(req.dest[SW-1:0]);
  assign f = RIC_FIELD_W'(req.source[SW-1:0]);

  // Range ends, one bit wider so that they never wrap
  assign t_w    = {1'b0, t};
  assign f_w    = {1'b0, f};
  assign n_w    = {1'b0, req.count};
  assign pt_w   = {1'b0, pend.dest};
  assign pf_w   = {1'b0, pend.source};
  assign pn_w   = {1'b0, pend.count};
  assign t_end  = t_w + n_w;
  assign f_end  = f_w + n_w;
  assign pt_end = pt_w + pn_w;
  assign pf_end = pf_w + pn_w;

  // Span of the merged destination range
  assign lo_dest   = (pt_w < t_w) ? pt_w : t_w;
  assign hi_dest   = (pt_end > t_end) ? pt_end : t_end;
  assign new_count = hi_dest - lo_dest;
  assign count_ok  = (new_count <= RIC_MAX_COUNT);

  // Clear merges when both ranges overlap or touch, there is no jump target and the count fits
  assign clear_merge = pend_valid && (pend.kind == KIND_CLEAR) && !req.jump_target &&
                       (((pt_w <= t_w) && (t_w <= pt_end)) ||
                        ((t_w <= pt_w) && (pt_w <= t_end))) && count_ok;

  // Copy merges on equal offset, touching sources and no overwrite of the new source
  assign copy_merge = pend_valid && !req.jump_target && !req.var_count &&
                      ((pend.kind == KIND_SINGLE) || (pend.kind == KIND_MULTI)) &&
                      ((pf_w + t_w) == (f_w + pt_w)) &&
                      (((f_w <= pf_w) && (pf_w <= f_end)) ||
                       ((pf_w <= f_w) && (f_w <= pf_end))) &&
                      ((pt_w >= f_end) || (pt_end <= f_w)) && count_ok;

  // Next pending state and emit decision for the item under work
  always_comb begin
    pend_valid_next = pend_valid;
    pend_next       = pend;
    emit            = 1'b0;
    merge           = 1'b0;
    if (go) begin
      case (req.mode)
        MODE_FLUSH: begin
          emit            = pend_valid;
          pend_valid_next = 1'b0;
        end
        MODE_OPAQUE: begin
          emit            = pend_valid;
          pend_valid_next = 1'b1;
          pend_next       = '{KIND_OPAQUE, '0, '0, '0, req.word};
        end
        MODE_CLEAR: begin
          if (clear_merge) begin
            merge          = 1'b1;
            pend_next.dest  = lo_dest[RIC_FIELD_W-1:0];
            pend_next.count = new_count[RIC_FIELD_W-1:0];
          end else begin
            emit            = pend_valid;
            pend_valid_next = 1'b1;
            pend_next       = '{KIND_CLEAR, t, '0, req.count, '0};
          end
        end
        MODE_COPY: begin
          if (req.count == '0) begin
            // Zero-count copy is dropped
          end else if (req.var_count) begin
            emit            = pend_valid;
            pend_valid_next = 1'b1;
            pend_next       = '{KIND_VAR, t, f, req.count, '0};
          end else if (copy_merge) begin
            merge            = 1'b1;
            pend_next.kind   = (new_count == EW'(1)) ? KIND_SINGLE : KIND_MULTI;
            pend_next.dest   = lo_dest[RIC_FIELD_W-1:0];
            pend_next.source = (pf_w < f_w) ? pend.source : f;
            pend_next.count  = new_count[RIC_FIELD_W-1:0];
          end else begin
            emit            = pend_valid;
            pend_valid_next = 1'b1;
            pend_next       = '{(req.count == RIC_FIELD_W'(1)) ? KIND_SINGLE : KIND_MULTI,
                                t, f, req.count, '0};
          end
        end
        default: begin
          pend_valid_next = pend_valid;
        end
      endcase
    end
  end

  // The emitted instruction is the pending one before the update
  assign result = pend;

  // Pending instruction register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  // A flush always leaves nothing pending
  assert property (@(posedge clk) disable iff (rst)
    go && (req.mode == MODE_FLUSH) |=> !pend_valid)
    else $error("pending instruction survived a flush");

  // An opaque request always becomes the pending instruction
  assert property (@(posedge clk) disable iff (rst)
    go && (req.mode == MODE_OPAQUE) |=> pend_valid && (pend.kind == KIND_OPAQUE))
    else $error("opaque request did not become pending");

  // Only a valid pending instruction is ever emitted
  assert property (@(posedge clk) disable iff (rst)
    emit |-> pend_valid)
    else $error("emitted an empty pending slot");

  // A merge never emits, and leaves the pending instruction valid
  assert property (@(posedge clk) disable iff (rst)
    merge |-> !emit ##1 pend_valid)
    else $error("merge emitted or lost the pending instruction");

endmodule

>>> hdl/ric_out_reg.sv
// Result register of the coalescer: holds one emitted instruction until taken.
// Depends on ric_pkg for the result type.
module ric_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          emit,
  input  ric_pkg::res_t result,
  input  logic          taken,
  output logic          out_valid,
  output ric_pkg::res_t out_res
);
  import ric_pkg::*;

  // Valid flag: a processed item loads its result (or none), a transfer empties it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end else if (taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_res <= result;
    end
  end

endmodule
